// ----- hdl/pcxrle_pkg.sv -----
// Shared types and constants for the run-length scanline decoder.
// No dependencies; imported by pcxrle_line_store and pcx_rle_scanline_decoder.
`default_nettype none

package pcxrle_pkg;

  // Image geometry limits
  localparam int MAX_BYTES_PER_LINE = 64;
  localparam int PLANES             = 4;
  localparam int STORE_DEPTH        = 256;
  localparam int STORE_AW           = $clog2(STORE_DEPTH);

  // Byte above this value opens a run; low six bits give the run length
  localparam logic [7:0] RUN_BASE = 8'hC0;

  // Pixels packed into one planar result
  localparam int GROUP_PIXELS = 8;

  // Plane read counter: counts 0..PLANES
  localparam int ISS_W = $clog2(PLANES + 1);
  localparam logic [ISS_W-1:0] ISS_DONE = ISS_W'(PLANES);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_COMPRESSED     = 2'd0,
    CFG_PIXEL_FORMAT   = 2'd1,
    CFG_BYTES_PER_LINE = 2'd2,
    CFG_IMAGE_WIDTH    = 2'd3
  } cfg_index_t;

  // Pixel format codes
  localparam logic [1:0] FMT_1BIT_1PLANE = 2'd0;
  localparam logic [1:0] FMT_1BIT_4PLANE = 2'd1;
  localparam logic [1:0] FMT_8BIT        = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_MREAD = 4'b0100,
    ST_MEMIT = 4'b1000
  } state_t;

  // Access request to the line store
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

endpackage

`default_nettype wire

// ----- hdl/pcx_rle_scanline_decoder.sv -----
// Top level of the run-length scanline decoder: sequencer, config and output register.
// Depends on pcxrle_pkg and pcxrle_line_store.
`default_nettype none

// Takes encoded image data one byte per request on the in_ channel and returns
// decoded scanline data on the out_ channel. A literal byte yields one decoded
// byte, a run value byte yields up to its run length of them, and a run count
// byte yields nothing. Each decoded byte is written into the line store, one
// write per cycle unless a visible byte waits for the output register. In planar
// mode the end of a line starts the merge: per group of eight pixels the store
// is read once per plane (four reads), the last read lands in the registered
// read port, and the group is then handed out. No new byte is accepted while a
// line is merged or a decoded byte is written out. A result waiting in the
// output register only stalls the sequencer when the next result is due.
// Configuration must be written through cfg_we/cfg_index/cfg_data while idle;
// the block itself does not enforce this.
module pcx_rle_scanline_decoder
  import pcxrle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] pixel_data, [35:32] pixel_count,
                                       // [44:36] out_position, [47:45] zero
  output logic             out_tlast,  // line_end
  output logic             out_tuser,  // last result of this input byte
  // Configuration port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic       compressed_r;
  logic [1:0] pixel_format_r;
  logic [6:0] bytes_per_line_r;
  logic [9:0] image_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_r     <= 1'b1;
      pixel_format_r   <= FMT_8BIT;
      bytes_per_line_r <= 7'(MAX_BYTES_PER_LINE);
      image_width_r    <= 10'd64;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_COMPRESSED:     compressed_r     <= cfg_data[0];
        CFG_PIXEL_FORMAT:   pixel_format_r   <= cfg_data[1:0];
        CFG_BYTES_PER_LINE: bytes_per_line_r <= cfg_data[6:0];
        CFG_IMAGE_WIDTH:    image_width_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Effective line geometry (registers must be written only while idle; not enforced)
  // ---------------------------------------------------------------------------
  logic       planar;
  logic [6:0] bpl_eff;     // 1..64
  logic [9:0] width_eff;   // 1..1023
  logic [8:0] line_size;   // bytes in one full line, all planes
  logic [7:0] limit;       // visible bytes in byte modes
  logic [9:0] width_pl;    // planar width, clamped to 8 * bpl
  logic [9:0] bpl_x8;
  logic [6:0] groups;      // planar groups per line
  logic [10:0] width_rnd;
  logic [10:0] width_pl_rnd;

  always_comb begin
    planar = (pixel_format_r == FMT_1BIT_4PLANE);

    // Treat zero as one, saturate above the store's line length
    if (bytes_per_line_r == 7'd0) begin
      bpl_eff = 7'd1;
    end else if (bytes_per_line_r > 7'(MAX_BYTES_PER_LINE)) begin
      bpl_eff = 7'(MAX_BYTES_PER_LINE);
    end else begin
      bpl_eff = bytes_per_line_r;
    end
    width_eff = (image_width_r == 10'd0) ? 10'd1 : image_width_r;

    line_size = planar ? {bpl_eff, 2'b00} : {2'b00, bpl_eff};

    // One-bit single plane: eight pixels a byte
    width_rnd = {1'b0, width_eff} + 11'd7;
    if (pixel_format_r == FMT_1BIT_1PLANE) begin
      limit = (width_rnd[10:3] > {1'b0, bpl_eff}) ? {1'b0, bpl_eff} : width_rnd[10:3];
    end else begin
      limit = (width_eff < {3'b000, bpl_eff}) ? width_eff[7:0] : {1'b0, bpl_eff};
    end

    bpl_x8       = {bpl_eff, 3'b000};
    width_pl     = (width_eff > bpl_x8) ? bpl_x8 : width_eff;
    width_pl_rnd = {1'b0, width_pl} + 11'd7;
    groups       = width_pl_rnd[9:3];
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t            state_r,        state_nxt;
  logic [7:0]        byte_r,         byte_nxt;
  logic [5:0]        remain_r,       remain_nxt;
  logic [8:0]        fill_index_r,   fill_index_nxt;
  logic              run_pending_r,  run_pending_nxt;
  logic [5:0]        run_length_r,   run_length_nxt;
  logic [5:0]        grp_r,          grp_nxt;
  logic [STORE_AW-1:0] addr_r,       addr_nxt;
  logic [ISS_W-1:0]  iss_r,          iss_nxt;
  logic              rd_vld_r;
  logic [31:0]       acc_r,          acc_nxt;

  // Output register
  logic              out_tvalid_r,   out_tvalid_nxt;
  logic [31:0]       out_data_r,     out_data_nxt;
  logic [3:0]        out_count_r,    out_count_nxt;
  logic [8:0]        out_pos_r,      out_pos_nxt;
  logic              out_end_r,      out_end_nxt;
  logic              out_last_r,     out_last_nxt;

  store_req_t        store_req;
  logic [7:0]        rd_data;

  // Scratch values of the sequencer
  logic              can_emit;
  logic              out_load;
  logic              emit_here;
  logic [9:0]        pos_inc;
  logic              line_done;
  logic [6:0]        grp_inc;
  logic [9:0]        cnt_full;
  logic [3:0]        cnt4;
  logic [31:0]       grp_mask;

  assign in_tready = (state_r == ST_IDLE);
  assign can_emit  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt       = state_r;
    byte_nxt        = byte_r;
    remain_nxt      = remain_r;
    fill_index_nxt  = fill_index_r;
    run_pending_nxt = run_pending_r;
    run_length_nxt  = run_length_r;
    grp_nxt         = grp_r;
    addr_nxt        = addr_r;
    iss_nxt         = iss_r;
    acc_nxt         = acc_r;

    out_load      = 1'b0;
    out_data_nxt  = out_data_r;
    out_count_nxt = out_count_r;
    out_pos_nxt   = out_pos_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;

    store_req = '0;

    emit_here = !planar && ({1'b0, fill_index_r} < {2'b00, limit});
    pos_inc   = {1'b0, fill_index_r} + 10'd1;
    line_done = pos_inc >= {1'b0, line_size};

    grp_inc  = {1'b0, grp_r} + 7'd1;
    cnt_full = width_pl - {1'b0, grp_r, 3'b000};
    cnt4     = (cnt_full > 10'(GROUP_PIXELS)) ? 4'(GROUP_PIXELS) : cnt_full[3:0];
    for (int k = 0; k < GROUP_PIXELS; k++) begin
      grp_mask[4*k +: 4] = (4'(k) < cnt4) ? 4'hF : 4'h0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (run_pending_r) begin
            // Byte after a run count is the run value, whatever the mode now
            run_pending_nxt = 1'b0;
            byte_nxt        = in_tdata;
            remain_nxt      = run_length_r;
            if (run_length_r != 6'd0) begin
              state_nxt = ST_RUN;
            end
          end else if (compressed_r && (in_tdata > RUN_BASE)) begin
            // Hold the count; this byte yields nothing
            run_length_nxt  = in_tdata[5:0];
            run_pending_nxt = 1'b1;
          end else begin
            byte_nxt   = in_tdata;
            remain_nxt = 6'd1;
            state_nxt  = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        // Hold while a visible byte has nowhere to go
        if (!(emit_here && !can_emit)) begin
          store_req.we    = 1'b1;
          store_req.waddr = fill_index_r[STORE_AW-1:0];
          store_req.wdata = byte_r;

          if (emit_here) begin
            out_load      = 1'b1;
            out_data_nxt  = {24'd0, byte_r};
            out_count_nxt = 4'd1;
            out_pos_nxt   = fill_index_r;
            out_end_nxt   = (pos_inc == {2'b00, limit});
            // Padding repeats after this one yield nothing
            out_last_nxt  = (remain_r == 6'd1) || (pos_inc >= {2'b00, limit});
          end

          remain_nxt     = remain_r - 6'd1;
          fill_index_nxt = line_done ? 9'd0 : pos_inc[8:0];

          if (line_done) begin
            // Drop the rest of a run that crosses the line end
            if (planar) begin
              state_nxt = ST_MREAD;
              grp_nxt   = 6'd0;
              addr_nxt  = '0;
              iss_nxt   = '0;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else if (remain_r == 6'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_MREAD: begin
        // Issue one plane read a cycle, plane p of group g at p * bpl + g
        if (iss_r != ISS_DONE) begin
          store_req.re    = 1'b1;
          store_req.raddr = addr_r;
          addr_nxt        = addr_r + STORE_AW'(bpl_eff);
          iss_nxt         = iss_r + ISS_W'(1);
        end
        // Shift each plane bit into the top of its pixel nibble; plane 0 ends lowest
        if (rd_vld_r) begin
          for (int k = 0; k < GROUP_PIXELS; k++) begin
            acc_nxt[4*k +: 4] = {rd_data[7-k], acc_r[4*k+1 +: 3]};
          end
          if (iss_r == ISS_DONE) begin
            state_nxt = ST_MEMIT;
          end
        end
      end

      ST_MEMIT: begin
        if (can_emit) begin
          out_load      = 1'b1;
          out_data_nxt  = acc_r & grp_mask;
          out_count_nxt = cnt4;
          out_pos_nxt   = {3'b000, grp_r};
          out_end_nxt   = (grp_inc == groups);
          out_last_nxt  = (grp_inc == groups);
          if (grp_inc == groups) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MREAD;
            grp_nxt   = grp_inc[5:0];
            addr_nxt  = STORE_AW'(grp_inc[5:0]);
            iss_nxt   = '0;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_tvalid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fill_index_r  <= 9'd0;
      run_pending_r <= 1'b0;
      run_length_r  <= 6'd0;
      rd_vld_r      <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fill_index_r  <= fill_index_nxt;
      run_pending_r <= run_pending_nxt;
      run_length_r  <= run_length_nxt;
      rd_vld_r      <= store_req.re;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    remain_r    <= remain_nxt;
    grp_r       <= grp_nxt;
    addr_r      <= addr_nxt;
    iss_r       <= iss_nxt;
    acc_r       <= acc_nxt;
    out_data_r  <= out_data_nxt;
    out_count_r <= out_count_nxt;
    out_pos_r   <= out_pos_nxt;
    out_end_r   <= out_end_nxt;
    out_last_r  <= out_last_nxt;
  end

  pcxrle_line_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_pos_r, out_count_r, out_data_r};
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/pcxrle_line_store.sv -----
// Line store: one write port and one read port, read data registered.
// Depends on pcxrle_pkg for the request struct and depth.
`default_nettype none

module pcxrle_line_store
  import pcxrle_pkg::*;
(
  input  wire logic       clk,
  input  wire store_req_t req,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  // Read returns the old entry on a same-cycle write; the sequencer never overlaps them
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
